### rtl/core/sfh_pkg.sv
// Package for the SuperFastHash bucket index block: transaction payload types,
// sequencer state type and the micro-operation program of the shared ALU.
// No dependencies.
package sfh_pkg;

    typedef struct packed {
        logic [7:0]  key_byte;
        logic [15:0] key_length;
        logic        last_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] hash_value;
        logic [31:0] bucket_index;
        logic        length_mismatch;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_TAIL,
        S_AVAL,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_XOR
    } t_alu_op;

    // Operand base before the shift.
    typedef enum logic [2:0] {
        SRC_SELF,
        SRC_LO,
        SRC_HI,
        SRC_SX2,
        SRC_SX0
    } t_src;

    typedef logic [4:0] t_pc;

    typedef struct packed {
        t_alu_op    op;
        t_src       src;
        logic       shr;
        logic [4:0] amt;
        logic       last;
    } t_uop;

    // Program entry points and the last remainder step.
    localparam t_pc PC_MIX  = 5'd0;
    localparam t_pc PC_T3   = 5'd4;
    localparam t_pc PC_T2   = 5'd8;
    localparam t_pc PC_T1   = 5'd11;
    localparam t_pc PC_AVAL = 5'd14;
    localparam t_pc PC_DIVL = 5'd31;

    function automatic t_uop sfh_uop(input t_pc pc);
        t_uop u;
        u = '{op: ALU_ADD, src: SRC_SELF, shr: 1'b0, amt: 5'd0, last: 1'b1};
        case (pc)
            // Four-byte chunk mixing.
            5'd0:  u = '{ALU_ADD, SRC_LO,   1'b0, 5'd0,  1'b0};
            5'd1:  u = '{ALU_XOR, SRC_SELF, 1'b0, 5'd16, 1'b0};
            5'd2:  u = '{ALU_XOR, SRC_HI,   1'b0, 5'd11, 1'b0};
            5'd3:  u = '{ALU_ADD, SRC_SELF, 1'b1, 5'd11, 1'b1};
            // Three-byte tail.
            5'd4:  u = '{ALU_ADD, SRC_LO,   1'b0, 5'd0,  1'b0};
            5'd5:  u = '{ALU_XOR, SRC_SELF, 1'b0, 5'd16, 1'b0};
            5'd6:  u = '{ALU_XOR, SRC_SX2,  1'b0, 5'd18, 1'b0};
            5'd7:  u = '{ALU_ADD, SRC_SELF, 1'b1, 5'd11, 1'b1};
            // Two-byte tail.
            5'd8:  u = '{ALU_ADD, SRC_LO,   1'b0, 5'd0,  1'b0};
            5'd9:  u = '{ALU_XOR, SRC_SELF, 1'b0, 5'd11, 1'b0};
            5'd10: u = '{ALU_ADD, SRC_SELF, 1'b1, 5'd17, 1'b1};
            // One-byte tail.
            5'd11: u = '{ALU_ADD, SRC_SX0,  1'b0, 5'd0,  1'b0};
            5'd12: u = '{ALU_XOR, SRC_SELF, 1'b0, 5'd10, 1'b0};
            5'd13: u = '{ALU_ADD, SRC_SELF, 1'b1, 5'd1,  1'b1};
            // Final avalanche.
            5'd14: u = '{ALU_XOR, SRC_SELF, 1'b0, 5'd3,  1'b0};
            5'd15: u = '{ALU_ADD, SRC_SELF, 1'b1, 5'd5,  1'b0};
            5'd16: u = '{ALU_XOR, SRC_SELF, 1'b0, 5'd4,  1'b0};
            5'd17: u = '{ALU_ADD, SRC_SELF, 1'b1, 5'd17, 1'b0};
            5'd18: u = '{ALU_XOR, SRC_SELF, 1'b0, 5'd25, 1'b0};
            5'd19: u = '{ALU_ADD, SRC_SELF, 1'b1, 5'd6,  1'b1};
            default: u = '{ALU_ADD, SRC_SELF, 1'b0, 5'd0, 1'b1};
        endcase
        return u;
    endfunction

    // Start of the tail program for a tail of n bytes (n = 1..3).
    function automatic t_pc sfh_tail_pc(input logic [1:0] n);
        t_pc pc;
        case (n)
            2'd3:    pc = PC_T3;
            2'd2:    pc = PC_T2;
            2'd1:    pc = PC_T1;
            default: pc = PC_AVAL;
        endcase
        return pc;
    endfunction

endpackage

### rtl/core/superfasthash_bucket_index_top.sv
// A byte that does not complete a chunk is only stored; a fourth byte starts the chunk mixing steps.
// After the last byte: the tail steps if any bytes are left over, the avalanche steps and the remainder steps, then the
// result is held until taken. An empty key gives its result on the next cycle.
// The shared add/xor/shift ALU and the one-bit-per-cycle remainder unit carry out these steps;
// one key is in work at a time. Reset (synchronous, active low) returns to idle, bucket_count 1024.
// Depends on sfh_pkg.
module superfasthash_bucket_index_top #(
    parameter logic [31:0] MAX_KEY_LENGTH = 32'd65535
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sfh_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sfh_pkg::t_out o_out_data
);
    import sfh_pkg::*;

    t_state      r_state, n_state;
    t_pc         r_pc, n_pc;
    logic        r_in_key, n_in_key;
    logic        r_fin, n_fin;
    logic [31:0] r_bucket_count;
    logic [31:0] r_h, n_h;
    logic [23:0] r_chunk, n_chunk;
    logic [7:0]  r_hi_byte, n_hi_byte;
    logic [15:0] r_seen, n_seen;
    logic [15:0] r_decl, n_decl;
    logic        r_ovf, n_ovf;
    logic        r_mism, n_mism;
    logic [31:0] r_dvd, n_dvd;
    logic [31:0] r_rem, n_rem;
    t_out        r_out, n_out;

    logic        w_accept;
    logic        w_first;
    logic        w_empty;
    logic [15:0] w_seen_base;
    logic [1:0]  w_pos;
    logic [15:0] w_seen_next;
    t_uop        w_uop;
    logic [31:0] w_base;
    logic [31:0] w_operand;
    logic [31:0] w_alu;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic [31:0] w_rem_next;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_first     = !r_in_key;
    assign w_empty     = w_first && (i_in_data.key_length == 16'd0);
    assign w_seen_base = w_first ? 16'd0 : r_seen;
    assign w_pos       = w_seen_base[1:0];
    assign w_seen_next = w_seen_base + 16'd1;

    // Shared ALU: one shifted operand, then add or xor into the working hash.
    assign w_uop = sfh_uop(r_pc);

    always_comb begin
        case (w_uop.src)
            SRC_SELF: w_base = r_h;
            SRC_LO:   w_base = {16'd0, r_chunk[15:0]};
            SRC_HI:   w_base = {16'd0, r_hi_byte, r_chunk[23:16]};
            SRC_SX2:  w_base = {{24{r_chunk[23]}}, r_chunk[23:16]};
            SRC_SX0:  w_base = {{24{r_chunk[7]}}, r_chunk[7:0]};
            default:  w_base = r_h;
        endcase
        w_operand = w_uop.shr ? (w_base >> w_uop.amt) : (w_base << w_uop.amt);
        w_alu     = (w_uop.op == ALU_ADD) ? (r_h + w_operand) : (r_h ^ w_operand);
    end

    // Restoring remainder step, one dividend bit per cycle.
    assign w_trial    = {r_rem, r_dvd[31]};
    assign w_diff     = w_trial - {1'b0, r_bucket_count};
    assign w_rem_next = w_diff[32] ? w_trial[31:0] : w_diff[31:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_empty) begin
                        n_state = i_in_data.last_byte ? S_OUT : S_IDLE;
                    end else if (w_pos == 2'd3) begin
                        n_state = S_MIX;
                    end else if (i_in_data.last_byte) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_MIX: begin
                if (w_uop.last) begin
                    n_state = r_fin ? S_AVAL : S_IDLE;
                end
            end
            S_TAIL: begin
                if (w_uop.last) begin
                    n_state = S_AVAL;
                end
            end
            S_AVAL: begin
                if (w_uop.last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_pc == PC_DIVL) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and sequencer outputs.
    always_comb begin
        n_pc      = r_pc;
        n_in_key  = r_in_key;
        n_fin     = r_fin;
        n_h       = r_h;
        n_chunk   = r_chunk;
        n_hi_byte = r_hi_byte;
        n_seen    = r_seen;
        n_decl    = r_decl;
        n_ovf     = r_ovf;
        n_mism    = r_mism;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_out     = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_empty) begin
                        n_out = '0;
                    end else begin
                        n_h     = w_first ? {16'd0, i_in_data.key_length} : r_h;
                        n_decl  = w_first ? i_in_data.key_length : r_decl;
                        n_chunk = w_first ? 24'd0 : r_chunk;
                        case (w_pos)
                            2'd0:    n_chunk[7:0]   = i_in_data.key_byte;
                            2'd1:    n_chunk[15:8]  = i_in_data.key_byte;
                            2'd2:    n_chunk[23:16] = i_in_data.key_byte;
                            default: n_hi_byte      = i_in_data.key_byte;
                        endcase
                        n_ovf    = (w_first ? 1'b0 : r_ovf) || (w_seen_base == 16'hFFFF);
                        n_seen   = w_seen_next;
                        n_in_key = !i_in_data.last_byte;
                        n_fin    = i_in_data.last_byte;
                        n_mism   = n_ovf || (w_seen_next != n_decl) ||
                                   ({16'd0, n_decl} > MAX_KEY_LENGTH);
                        if (w_pos == 2'd3) begin
                            n_pc = PC_MIX;
                        end else begin
                            n_pc = sfh_tail_pc(w_seen_next[1:0]);
                        end
                    end
                end
            end
            S_MIX: begin
                n_h  = w_alu;
                n_pc = r_pc + 5'd1;
                if (w_uop.last) begin
                    n_chunk = 24'd0;
                    n_pc    = PC_AVAL;
                end
            end
            S_TAIL: begin
                n_h  = w_alu;
                n_pc = w_uop.last ? PC_AVAL : (r_pc + 5'd1);
            end
            S_AVAL: begin
                n_h  = w_alu;
                n_pc = r_pc + 5'd1;
                if (w_uop.last) begin
                    n_dvd = w_alu;
                    n_rem = 32'd0;
                    n_pc  = 5'd0;
                end
            end
            S_DIV: begin
                n_rem = w_rem_next;
                n_dvd = {r_dvd[30:0], 1'b0};
                n_pc  = r_pc + 5'd1;
                if (r_pc == PC_DIVL) begin
                    n_out.hash_value      = r_h;
                    n_out.bucket_index    = (r_bucket_count == 32'd0) ? 32'd0 : w_rem_next;
                    n_out.length_mismatch = r_mism;
                end
            end
            S_OUT: begin
                n_fin = 1'b0;
            end
            default: begin
                n_pc = r_pc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pc           <= 5'd0;
            r_in_key       <= 1'b0;
            r_fin          <= 1'b0;
            r_seen         <= 16'd0;
            r_decl         <= 16'd0;
            r_ovf          <= 1'b0;
            r_bucket_count <= 32'd1024;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_in_key <= n_in_key;
            r_fin    <= n_fin;
            r_seen   <= n_seen;
            r_decl   <= n_decl;
            r_ovf    <= n_ovf;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h       <= n_h;
        r_chunk   <= n_chunk;
        r_hi_byte <= n_hi_byte;
        r_mism    <= n_mism;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_out     <= n_out;
    end

endmodule

### tb/superfasthash_bucket_index_top_tb.sv
// Self-checking testbench for superfasthash_bucket_index_top: streams keys byte by byte and
// checks every hash, bucket index and length flag against a built-in SuperFastHash predictor.
// Depends on sfh_pkg and the superfasthash_bucket_index_top RTL.
`timescale 1ns / 100ps

module superfasthash_bucket_index_top_tb;

    localparam int          RANDOM_PER_PHASE = 150;
    localparam int          PHASE_COUNT      = 7;
    localparam int          SETTLE_CYCLES    = 64;
    localparam int          TIMEOUT_CYCLES   = 2_000_000;
    localparam logic [31:0] KEY_LENGTH_LIMIT = 32'd65535;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [31:0]   i_cfg_wdata = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    sfh_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    sfh_pkg::t_out o_out_data;

    superfasthash_bucket_index_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predictor state, mirroring the block.
    logic [31:0] key_hash     = '0;
    logic [23:0] key_chunk    = '0;
    logic [15:0] key_seen     = '0;
    logic [15:0] key_declared = '0;
    logic        key_open     = 1'b0;
    logic        key_wrapped  = 1'b0;
    logic [31:0] model_divisor = 32'd1024;

    sfh_pkg::t_in  key_stream[$];
    sfh_pkg::t_out expected_digests[$];

    int          error_count    = 0;
    int          accepted_count = 0;
    int          results_checked = 0;
    int          mismatch_flags = 0;
    int          items_queued   = 0;
    int          settings_used  = 0;

    // Sender burst control and receiver stall pattern.
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          max_gap     = 6;
    logic        in_flight   = 1'b0;
    logic [15:0] stall_pattern = 16'hA5C3;
    int          pattern_age = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] tail_and_avalanche(input logic [31:0] h_in,
                                                       input logic [23:0] pend,
                                                       input logic [1:0] n);
        logic [31:0] h;
        h = h_in;
        case (n)
            2'd3: begin
                h = h + {16'd0, pend[15:0]};
                h = h ^ (h << 16);
                h = h ^ ({{24{pend[23]}}, pend[23:16]} << 18);
                h = h + (h >> 11);
            end
            2'd2: begin
                h = h + {16'd0, pend[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1: begin
                h = h + {{24{pend[7]}}, pend[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: ;
        endcase
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    // Advances the predictor by one accepted byte; returns 1 when a result is due.
    function automatic bit predict_digest(input sfh_pkg::t_in item, output sfh_pkg::t_out digest);
        logic [31:0] h;
        logic [31:0] t;
        logic [15:0] hi;
        logic [1:0]  pos;
        digest = '0;
        if (!key_open) begin
            // An empty key answers with zeros; without the last mark the byte is ignored.
            if (item.key_length == 16'd0)
                return item.last_byte;
            key_declared = item.key_length;
            key_hash     = {16'd0, item.key_length};
            key_chunk    = '0;
            key_seen     = '0;
            key_wrapped  = 1'b0;
            key_open     = 1'b1;
        end
        pos = key_seen[1:0];
        if (pos != 2'd3) begin
            key_chunk[8*pos +: 8] = item.key_byte;
        end else begin
            hi = {item.key_byte, key_chunk[23:16]};
            h = key_hash + {16'd0, key_chunk[15:0]};
            t = ({16'd0, hi} << 11) ^ h;
            h = (h << 16) ^ t;
            h = h + (h >> 11);
            key_hash  = h;
            key_chunk = '0;
        end
        if (key_seen == 16'hFFFF)
            key_wrapped = 1'b1;
        key_seen = key_seen + 16'd1;
        if (!item.last_byte)
            return 1'b0;
        h = tail_and_avalanche(key_hash, key_chunk, key_seen[1:0]);
        digest.hash_value      = h;
        digest.bucket_index    = (model_divisor == 32'd0) ? 32'd0 : h % model_divisor;
        digest.length_mismatch = key_wrapped || key_seen != key_declared ||
                                 {16'd0, key_declared} > KEY_LENGTH_LIMIT;
        key_open     = 1'b0;
        key_hash     = '0;
        key_chunk    = '0;
        key_seen     = '0;
        key_declared = '0;
        key_wrapped  = 1'b0;
        return 1'b1;
    endfunction

    // Input driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        sfh_pkg::t_in  item;
        sfh_pkg::t_out digest;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_flight = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                accepted_count++;
                if (predict_digest(i_in_data, digest))
                    expected_digests.push_back(digest);
                in_flight = 1'b0;
            end
            if (!in_flight) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (key_stream.size() > 0) begin
                    item = key_stream.pop_front();
                    i_in_data  <= item;
                    i_in_valid <= 1'b1;
                    in_flight = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        sfh_pkg::t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_digests.size() == 0) begin
                    $error("unexpected result transaction: hash_value %h", o_out_data.hash_value);
                    error_count++;
                end else begin
                    want = expected_digests.pop_front();
                    results_checked++;
                    if (want.length_mismatch)
                        mismatch_flags++;
                    if (o_out_data.hash_value !== want.hash_value) begin
                        $error("hash_value: expected %h, actual %h",
                               want.hash_value, o_out_data.hash_value);
                        error_count++;
                    end
                    if (o_out_data.bucket_index !== want.bucket_index) begin
                        $error("bucket_index: expected %h, actual %h",
                               want.bucket_index, o_out_data.bucket_index);
                        error_count++;
                    end
                    if (o_out_data.length_mismatch !== want.length_mismatch) begin
                        $error("length_mismatch: expected %b, actual %b",
                               want.length_mismatch, o_out_data.length_mismatch);
                        error_count++;
                    end
                end
            end
            pattern_age++;
            if (pattern_age == 48) begin
                pattern_age = 0;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                if (stall_pattern == 16'd0)
                    stall_pattern = 16'h0001;
            end else begin
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
            i_out_ready <= stall_pattern[0];
        end
    end

    task automatic push_item(input logic [7:0] key_byte, input logic [15:0] key_length,
                             input logic last_byte);
        sfh_pkg::t_in item;
        item.key_byte   = key_byte;
        item.key_length = key_length;
        item.last_byte  = last_byte;
        key_stream.push_back(item);
    endtask

    function automatic logic [7:0] pick_byte(input bit extreme);
        logic [7:0] b;
        b = 8'($urandom);
        if (extreme) begin
            case ($urandom_range(0, 3))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h7F;
                default: b = 8'h80;
            endcase
        end
        return b;
    endfunction

    // Mostly well-formed keys; some empty, some with a wrong declared length, some noise.
    task automatic queue_random_key();
        int          r;
        int          n;
        bit          extreme;
        logic [15:0] decl;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            push_item(8'($urandom), 16'd0, 1'b0);
        end else if (r < 10) begin
            push_item(8'($urandom), 16'd0, 1'b1);
            items_queued++;
        end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            decl = 16'(n);
            if (r < 22)
                decl = 16'($urandom_range(1, 65535));
            extreme = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < n; k++)
                push_item(pick_byte(extreme), (k == 0) ? decl : 16'($urandom), k == n - 1);
            items_queued += n;
        end
    endtask

    task automatic drain();
        while (key_stream.size() != 0 || in_flight || expected_digests.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_divisor(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_divisor = value;
    endtask

    initial begin
        logic [31:0] divisor;
        while (!i_rst_n) @(posedge i_clk);
        @(posedge i_clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: divisor = 32'd1;
                    2: divisor = 32'd0;
                    3: divisor = 32'hFFFF_FFFF;
                    4: divisor = $urandom;
                    5: divisor = 32'h8000_0000;
                    default: divisor = 32'd7;
                endcase
                write_divisor(divisor);
            end
            settings_used++;

            if (phase == 0) begin
                push_item(8'h5A, 16'd0, 1'b1);        // empty key
                push_item(8'hC3, 16'd0, 1'b0);        // ignored while waiting
                push_item(8'hFF, 16'd1, 1'b1);        // lone tail byte, negative
                push_item(8'h7F, 16'd1, 1'b1);
                push_item(8'hFF, 16'd2, 1'b0);
                push_item(8'hFF, 16'hFFFF, 1'b1);
                push_item(8'h80, 16'd3, 1'b0);        // third tail byte sign-extended
                push_item(8'h00, 16'd0, 1'b0);
                push_item(8'hFF, 16'd0, 1'b1);
                for (int k = 0; k < 4; k++)
                    push_item(8'hFF, (k == 0) ? 16'd4 : 16'hFFFF, k == 3);
                push_item(8'h00, 16'hFFFF, 1'b0);     // short key
                push_item(8'h80, 16'd0, 1'b1);
                for (int k = 0; k < 5; k++)          // long key
                    push_item(8'(8'h11 * k), 16'd1, k == 4);
            end

            items_queued = 0;
            while (items_queued < RANDOM_PER_PHASE)
                queue_random_key();
            drain();
        end

        $display("tb: %0d input transactions accepted, %0d results checked (%0d with length flag)",
                 accepted_count, results_checked, mismatch_flags);
        $display("tb: %0d divisor settings including 0, 1 and all ones, with empty and odd keys",
                 settings_used);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
